### rtl/adaptive_frame_quality_governor_unit_macros.svh
// Assertion helpers for the frame quality governor.
`ifndef ADAPTIVE_FRAME_QUALITY_GOVERNOR_UNIT_MACROS_SVH
`define ADAPTIVE_FRAME_QUALITY_GOVERNOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AFQG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define AFQG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/afqg_pkg.sv
package afqg_pkg;

    localparam int unsigned FT_W     = 20;
    localparam int unsigned AVG_W    = 28;
    localparam int unsigned MUL_A_W  = 28;
    localparam int unsigned MUL_B_W  = 20;
    localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int unsigned ACC_W    = 37;
    localparam int unsigned LOAD_W   = 38;
    localparam int unsigned THR_W    = 30;

    localparam logic [7:0]         STREAK_NEEDED   = 8'd10;
    localparam logic [7:0]         COOLDOWN_LEN    = 8'd5;
    localparam logic [1:0]         MAX_FOVEATION   = 2'd3;
    localparam logic [AVG_W-1:0]   Q8_MAX          = {AVG_W{1'b1}};
    localparam logic [MUL_B_W-1:0] MILLION         = 20'd1000000;
    localparam logic [9:0]         DEFAULT_HZ      = 10'd90;
    localparam logic [8:0]         WEIGHT_ONE      = 9'd256;

    // register reset values
    localparam logic       RST_ENABLE    = 1'b0;
    localparam logic [6:0] RST_MIN_SCALE = 7'd50;
    localparam logic [7:0] RST_MAX_SCALE = 8'd100;
    localparam logic [4:0] RST_STEP      = 5'd5;
    localparam logic [8:0] RST_SMOOTHING = 9'd26;
    localparam logic [9:0] RST_OVERSHOOT = 10'd256;
    localparam logic [9:0] RST_HEADROOM  = 10'd205;
    localparam logic [9:0] RST_REFRESH   = 10'd0;

    typedef enum logic [2:0] {
        REG_ENABLE    = 3'd0,
        REG_MIN_SCALE = 3'd1,
        REG_MAX_SCALE = 3'd2,
        REG_STEP      = 3'd3,
        REG_SMOOTHING = 3'd4,
        REG_OVERSHOOT = 3'd5,
        REG_HEADROOM  = 3'd6,
        REG_REFRESH   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ACT_HOLD     = 2'd0,
        ACT_REDUCE   = 2'd1,
        ACT_INCREASE = 2'd2,
        ACT_SKIP     = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMA_A,
        ST_EMA_B,
        ST_EMA_C,
        ST_LOAD,
        ST_OVER,
        ST_HEAD,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

endpackage

### rtl/afqg_mul.sv
// Shared multiplier, product registered when enabled and held otherwise.
module afqg_mul
    import afqg_pkg::*;
(
    input  logic               i_clk,
    input  t_mul_req           i_req,
    output logic [MUL_P_W-1:0] o_p
);

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_p <= {{MUL_B_W{1'b0}}, i_req.a} * {{MUL_A_W{1'b0}}, i_req.b};
        end
    end

    assign o_p = r_p;

endmodule

### rtl/adaptive_frame_quality_governor_unit.sv
// Adaptive frame quality governor.
// Input channel: one beat per frame carries i_frame_time_us (i_valid / o_stall).
// Output channel: one beat per input beat with render scale, foveation level,
// change flags, action code and the smoothed frame time (o_valid / i_stall).
// APB port: eight registers at byte addresses 0..28, pready tied high.
// Sequencing: one shared 28x20 multiplier does the average update, the load product
// and both thresholds in turn. An enabled item steps through EMA_A, EMA_B, EMA_C,
// LOAD, OVER, HEAD and DECIDE to the result register; the first sample (no blend)
// skips the EMA steps and a disabled item goes straight to DECIDE. A new beat is
// taken only in idle. o_stall is high from accept until the result is written.
// The result sits in an output register; the next beat is accepted while it
// waits. If the result register is still full and stalled when the next
// decision is ready, the sequencer holds in its decide step until it drains.
// Reset (synchronous, active low) restores register defaults, clears the
// average, cooldown and streak, sets scale to 100 and foveation to 0.
`include "adaptive_frame_quality_governor_unit_macros.svh"

module adaptive_frame_quality_governor_unit
    import afqg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [FT_W-1:0]   i_frame_time_us,
    // output channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_render_scale,
    output logic [1:0]        o_foveation_level,
    output logic              o_scale_changed,
    output logic              o_foveation_changed,
    output logic [1:0]        o_action,
    output logic [FT_W-1:0]   o_average_time_us,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic       r_enable;
    logic [6:0] r_min_scale;
    logic [7:0] r_max_scale;
    logic [4:0] r_scale_step;
    logic [8:0] r_smoothing;
    logic [9:0] r_overshoot;
    logic [9:0] r_headroom;
    logic [9:0] r_refresh;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= RST_ENABLE;
            r_min_scale  <= RST_MIN_SCALE;
            r_max_scale  <= RST_MAX_SCALE;
            r_scale_step <= RST_STEP;
            r_smoothing  <= RST_SMOOTHING;
            r_overshoot  <= RST_OVERSHOOT;
            r_headroom   <= RST_HEADROOM;
            r_refresh    <= RST_REFRESH;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ENABLE:    r_enable     <= pwdata[0];
                REG_MIN_SCALE: r_min_scale  <= pwdata[6:0];
                REG_MAX_SCALE: r_max_scale  <= pwdata[7:0];
                REG_STEP:      r_scale_step <= pwdata[4:0];
                REG_SMOOTHING: r_smoothing  <= pwdata[8:0];
                REG_OVERSHOOT: r_overshoot  <= pwdata[9:0];
                REG_HEADROOM:  r_headroom   <= pwdata[9:0];
                REG_REFRESH:   r_refresh    <= pwdata[9:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ENABLE:    prdata = {31'd0, r_enable};
            REG_MIN_SCALE: prdata = {25'd0, r_min_scale};
            REG_MAX_SCALE: prdata = {24'd0, r_max_scale};
            REG_STEP:      prdata = {27'd0, r_scale_step};
            REG_SMOOTHING: prdata = {23'd0, r_smoothing};
            REG_OVERSHOOT: prdata = {22'd0, r_overshoot};
            REG_HEADROOM:  prdata = {22'd0, r_headroom};
            REG_REFRESH:   prdata = {22'd0, r_refresh};
        endcase
    end

    // ---------------------------------------------------------------
    // Governor state and sequencer
    // ---------------------------------------------------------------
    t_state              r_state, n_state;
    logic [FT_W-1:0]     r_x, n_x;
    logic [AVG_W-1:0]    r_avg, n_avg;
    logic [ACC_W-1:0]    r_acc, n_acc;     // old average times (1 - w)
    logic [LOAD_W-1:0]   r_load, n_load;   // average times refresh rate
    logic [THR_W-1:0]    r_over, n_over;   // overshoot threshold
    logic [7:0]          r_cool, n_cool;
    logic [7:0]          r_run, n_run;
    logic [7:0]          r_scale, n_scale;
    logic [1:0]          r_fov, n_fov;

    // result register
    logic                r_o_valid, n_o_valid;
    logic [7:0]          r_o_scale, n_o_scale;
    logic [1:0]          r_o_fov, n_o_fov;
    logic                r_o_scale_chg, n_o_scale_chg;
    logic                r_o_fov_chg, n_o_fov_chg;
    t_action             r_o_action, n_o_action;
    logic [FT_W-1:0]     r_o_avg, n_o_avg;

    t_mul_req            mul_req;
    logic [MUL_P_W-1:0]  mul_p;

    logic [8:0]          weight;
    logic [9:0]          hz;
    logic [LOAD_W-1:0]   ema_sum;
    logic                over_hit, head_hit;
    logic [7:0]          run_inc;

    // quality moves
    logic [8:0]          red_diff, inc_sum;
    logic [7:0]          red_scale, inc_scale;
    logic [1:0]          red_fov, inc_fov;

    afqg_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_p   (mul_p)
    );

    assign weight  = (r_smoothing > WEIGHT_ONE) ? WEIGHT_ONE : r_smoothing;
    assign hz      = (r_refresh == 10'd0) ? DEFAULT_HZ : r_refresh;
    assign ema_sum = {1'b0, r_acc} + {1'b0, mul_p[28:0], 8'd0};

    // in the decide step the multiplier still holds the headroom threshold
    assign over_hit = r_load > {{(LOAD_W-THR_W){1'b0}}, r_over};
    assign head_hit = r_load < {{(LOAD_W-THR_W){1'b0}}, mul_p[THR_W-1:0]};
    assign run_inc  = (r_run == 8'hFF) ? r_run : r_run + 8'd1;

    // reduce: foveation first, then scale down to the floor
    assign red_diff = {1'b0, r_scale} - {4'd0, r_scale_step};
    always_comb begin
        red_scale = r_scale;
        red_fov   = r_fov;
        if (r_fov < MAX_FOVEATION) begin
            red_fov = r_fov + 2'd1;
        end else if (r_scale > {1'b0, r_min_scale}) begin
            if (red_diff[8] || red_diff[7:0] < {1'b0, r_min_scale}) begin
                red_scale = {1'b0, r_min_scale};
            end else begin
                red_scale = red_diff[7:0];
            end
        end
    end

    // increase: scale first, then foveation back towards none
    assign inc_sum = {1'b0, r_scale} + {4'd0, r_scale_step};
    always_comb begin
        inc_scale = r_scale;
        inc_fov   = r_fov;
        if (r_scale < r_max_scale) begin
            inc_scale = (inc_sum > {1'b0, r_max_scale}) ? r_max_scale : inc_sum[7:0];
        end else if (r_fov != 2'd0) begin
            inc_fov = r_fov - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_avg     <= '0;
            r_cool    <= '0;
            r_run     <= '0;
            r_scale   <= RST_MAX_SCALE;
            r_fov     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_avg     <= n_avg;
            r_cool    <= n_cool;
            r_run     <= n_run;
            r_scale   <= n_scale;
            r_fov     <= n_fov;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x           <= n_x;
        r_acc         <= n_acc;
        r_load        <= n_load;
        r_over        <= n_over;
        r_o_scale     <= n_o_scale;
        r_o_fov       <= n_o_fov;
        r_o_scale_chg <= n_o_scale_chg;
        r_o_fov_chg   <= n_o_fov_chg;
        r_o_action    <= n_o_action;
        r_o_avg       <= n_o_avg;
    end

    always_comb begin
        n_state       = r_state;
        n_x           = r_x;
        n_avg         = r_avg;
        n_acc         = r_acc;
        n_load        = r_load;
        n_over        = r_over;
        n_cool        = r_cool;
        n_run         = r_run;
        n_scale       = r_scale;
        n_fov         = r_fov;
        n_o_valid     = r_o_valid && i_stall;
        n_o_scale     = r_o_scale;
        n_o_fov       = r_o_fov;
        n_o_scale_chg = r_o_scale_chg;
        n_o_fov_chg   = r_o_fov_chg;
        n_o_action    = r_o_action;
        n_o_avg       = r_o_avg;
        mul_req       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_x = i_frame_time_us;
                    if (!r_enable) begin
                        n_state = ST_DECIDE;
                    end else if (r_avg == '0) begin
                        // first sample loads the average as is
                        n_avg   = {i_frame_time_us, 8'd0};
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_EMA_A;
                    end
                end
            end
            ST_EMA_A: begin
                mul_req = '{en: 1'b1, a: r_avg,
                            b: {{(MUL_B_W-9){1'b0}}, WEIGHT_ONE - weight}};
                n_state = ST_EMA_B;
            end
            ST_EMA_B: begin
                mul_req = '{en: 1'b1, a: {{(MUL_A_W-FT_W){1'b0}}, r_x},
                            b: {{(MUL_B_W-9){1'b0}}, weight}};
                n_acc   = mul_p[ACC_W-1:0];
                n_state = ST_EMA_C;
            end
            ST_EMA_C: begin
                n_avg   = (ema_sum[LOAD_W-1:AVG_W+8] != '0) ? Q8_MAX
                                                            : ema_sum[AVG_W+7:8];
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                mul_req = '{en: 1'b1, a: r_avg, b: {{(MUL_B_W-10){1'b0}}, hz}};
                n_state = ST_OVER;
            end
            ST_OVER: begin
                mul_req = '{en: 1'b1, a: {{(MUL_A_W-10){1'b0}}, r_overshoot},
                            b: MILLION};
                n_load  = mul_p[LOAD_W-1:0];
                n_state = ST_HEAD;
            end
            ST_HEAD: begin
                mul_req = '{en: 1'b1, a: {{(MUL_A_W-10){1'b0}}, r_headroom},
                            b: MILLION};
                n_over  = mul_p[THR_W-1:0];
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_action = ACT_HOLD;
                    if (!r_enable) begin
                        n_scale = r_max_scale;
                        n_fov   = 2'd0;
                    end else if (r_cool != 8'd0) begin
                        n_cool     = r_cool - 8'd1;
                        n_o_action = ACT_SKIP;
                    end else if (over_hit) begin
                        n_run      = 8'd0;
                        n_scale    = red_scale;
                        n_fov      = red_fov;
                        n_cool     = COOLDOWN_LEN;
                        n_o_action = ACT_REDUCE;
                    end else if (head_hit) begin
                        if (run_inc >= STREAK_NEEDED) begin
                            n_run      = 8'd0;
                            n_scale    = inc_scale;
                            n_fov      = inc_fov;
                            n_cool     = COOLDOWN_LEN;
                            n_o_action = ACT_INCREASE;
                        end else begin
                            n_run = run_inc;
                        end
                    end else begin
                        n_run = 8'd0;
                    end
                    n_o_valid     = 1'b1;
                    n_o_scale     = n_scale;
                    n_o_fov       = n_fov;
                    // when disabled both change flags are forced low
                    n_o_scale_chg = r_enable && (n_scale != r_scale);
                    n_o_fov_chg   = r_enable && (n_fov != r_fov);
                    n_o_avg       = r_avg[AVG_W-1:8];
                    n_state       = ST_IDLE;
                end
            end
        endcase

        // disabling forces full quality straight away
        if (cfg_wr && cfg_idx == REG_ENABLE && !pwdata[0]) begin
            n_scale = r_max_scale;
            n_fov   = 2'd0;
        end
    end

    assign o_stall             = (r_state != ST_IDLE);
    assign o_valid             = r_o_valid;
    assign o_render_scale      = r_o_scale;
    assign o_foveation_level   = r_o_fov;
    assign o_scale_changed     = r_o_scale_chg;
    assign o_foveation_changed = r_o_fov_chg;
    assign o_action            = r_o_action;
    assign o_average_time_us   = r_o_avg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `AFQG_ASSERT_NXT(a_enabled_beat_works, i_clk, i_rst_n,
        (i_valid && !o_stall && r_enable), (r_state != ST_IDLE && r_state != ST_DECIDE),
        "enabled beat skipped the arithmetic")
    `AFQG_ASSERT_IMP(a_change_needs_move, i_clk, i_rst_n,
        (r_o_valid && (r_o_scale_chg || r_o_fov_chg)),
        (r_o_action == ACT_REDUCE || r_o_action == ACT_INCREASE),
        "quality changed without a reduce or increase")
    `AFQG_ASSERT_IMP(a_cooldown_bound, i_clk, i_rst_n,
        1'b1, (r_cool <= COOLDOWN_LEN),
        "cooldown counter out of range")
    `AFQG_ASSERT_NXT(a_decide_waits, i_clk, i_rst_n,
        (r_state == ST_DECIDE && r_o_valid && i_stall), (r_state == ST_DECIDE),
        "result register overwritten while stalled")
    `AFQG_ASSERT_IMP(a_one_change_kind, i_clk, i_rst_n,
        (r_o_valid && r_o_scale_chg), (!r_o_fov_chg),
        "scale and foveation changed in one frame")

endmodule

### sim/adaptive_frame_quality_governor_unit_test.sv
// Frame quality governor testbench.
//
// The stimulus side sends one beat per frame time, with random gaps between beats.
// A mirror of the governor predicts the outcome of every accepted beat: the smoothed
// average, cooldown, headroom streak, scale and foveation. It queues the prediction
// in order. The result side stalls at random. It compares every accepted result beat,
// field by field, with the oldest queued prediction.
//
// Registers are only touched over APB while nothing is in flight. The register
// mirror follows every write, including the forced return to full quality that a
// disable write causes.
//
// Order of work:
//   - held at full quality while disabled
//   - register read-back at both ends of each width
//   - first-sample load, frozen average, over-unity weight and a zero reload
//   - foveation climbing to its ceiling, then a reduction with nothing left
//     under inverted scale limits
//   - twelve random phases, mostly runs of frames pitched around the headroom
//     and overshoot thresholds, with some noise mixed in
module adaptive_frame_quality_governor_unit_test;
    import afqg_pkg::*;

    // one predicted result beat
    typedef struct packed {
        logic [7:0]      scale;
        logic [1:0]      fov;
        logic            scale_chg;
        logic            fov_chg;
        t_action         action;
        logic [FT_W-1:0] avg_us;
    } t_gov_outcome;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [FT_W-1:0]   i_frame_time_us = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [7:0]        o_render_scale;
    logic [1:0]        o_foveation_level;
    logic              o_scale_changed;
    logic              o_foveation_changed;
    logic [1:0]        o_action;
    logic [FT_W-1:0]   o_average_time_us;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [4:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // register mirror, starting from the reset values
    logic              cfg_enable     = RST_ENABLE;
    logic [6:0]        cfg_min_scale  = RST_MIN_SCALE;
    logic [7:0]        cfg_max_scale  = RST_MAX_SCALE;
    logic [4:0]        cfg_step       = RST_STEP;
    logic [8:0]        cfg_smoothing  = RST_SMOOTHING;
    logic [9:0]        cfg_overshoot  = RST_OVERSHOOT;
    logic [9:0]        cfg_headroom   = RST_HEADROOM;
    logic [9:0]        cfg_refresh_hz = RST_REFRESH;

    // governor state mirror
    logic [AVG_W-1:0]  gov_avg_q8   = '0;
    logic [7:0]        gov_cooldown = '0;
    logic [7:0]        gov_streak   = '0;
    logic [7:0]        gov_scale    = RST_MAX_SCALE;
    logic [1:0]        gov_fov      = '0;

    t_gov_outcome      frame_outcomes[$];
    int unsigned       mismatch_count = 0;
    int unsigned       stall_left = 0;
    bit                no_idle = 1'b0;

    adaptive_frame_quality_governor_unit i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_frame_time_us     (i_frame_time_us),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_render_scale      (o_render_scale),
        .o_foveation_level   (o_foveation_level),
        .o_scale_changed     (o_scale_changed),
        .o_foveation_changed (o_foveation_changed),
        .o_action            (o_action),
        .o_average_time_us   (o_average_time_us),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Idle length for either side. Most gaps are short and a few are long.
    // Quiet phases switch idling off altogether.
    function automatic int unsigned pick_idle();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned reg_width(t_reg_idx idx);
        case (idx)
            REG_ENABLE:    return 1;
            REG_MIN_SCALE: return 7;
            REG_MAX_SCALE: return 8;
            REG_STEP:      return 5;
            REG_SMOOTHING: return 9;
            default:       return 10;
        endcase
    endfunction

    // Mostly inside the usual range, with the odd raw value or end of the width
    // so that inverted limits, a zero step and an over-unity weight all turn up.
    function automatic logic [31:0] pick_reg_value(t_reg_idx idx, int unsigned lo,
                                                   int unsigned hi);
        logic [31:0] mask;
        int unsigned r;
        mask = (32'd1 << reg_width(idx)) - 32'd1;
        r = $urandom_range(0, 99);
        if (r < 8)  return $urandom & mask;
        if (r < 12) return 32'd0;
        if (r < 16) return mask;
        return $urandom_range(lo, hi);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic void force_full_quality();
        gov_scale = cfg_max_scale;
        gov_fov   = '0;
    endfunction

    function automatic void mirror_register(t_reg_idx idx, logic [31:0] value);
        case (idx)
            REG_ENABLE: begin
                cfg_enable = value[0];
                // a disable write snaps back to full quality at once
                if (!value[0]) force_full_quality();
            end
            REG_MIN_SCALE: cfg_min_scale  = value[6:0];
            REG_MAX_SCALE: cfg_max_scale  = value[7:0];
            REG_STEP:      cfg_step       = value[4:0];
            REG_SMOOTHING: cfg_smoothing  = value[8:0];
            REG_OVERSHOOT: cfg_overshoot  = value[9:0];
            REG_HEADROOM:  cfg_headroom   = value[9:0];
            REG_REFRESH:   cfg_refresh_hz = value[9:0];
            default: ;
        endcase
    endfunction

    // Advance the governor mirror by one frame and return what it reports.
    function automatic t_gov_outcome govern_frame(logic [FT_W-1:0] ft);
        t_gov_outcome res;
        logic [7:0]        prev_scale;
        logic [1:0]        prev_fov;
        longint unsigned   w, hz, acc, load;
        int                s;
        res.action = ACT_HOLD;
        if (!cfg_enable) begin
            // the average, cooldown and streak are frozen
            force_full_quality();
            prev_scale = gov_scale;
            prev_fov   = gov_fov;
        end else begin
            w  = (cfg_smoothing > WEIGHT_ONE) ? 256 : cfg_smoothing;
            hz = (cfg_refresh_hz == 0) ? 90 : cfg_refresh_hz;
            // a zero average means no sample yet, so the frame loads it directly
            if (gov_avg_q8 == 0) begin
                gov_avg_q8 = {ft, 8'd0};
            end else begin
                acc = (gov_avg_q8 * (WEIGHT_ONE - w) + {ft, 8'd0} * w) >> 8;
                gov_avg_q8 = (acc > Q8_MAX) ? Q8_MAX : acc[AVG_W-1:0];
            end
            prev_scale = gov_scale;
            prev_fov   = gov_fov;
            // exact budget test: avg * hz against ratio * 1e6, both in Q8
            load = gov_avg_q8 * hz;
            if (gov_cooldown != 0) begin
                gov_cooldown--;
                res.action = ACT_SKIP;
            end else if (load > cfg_overshoot * 64'd1000000) begin
                // foveation first, then scale; may change nothing at all
                gov_streak = '0;
                if (gov_fov < MAX_FOVEATION) begin
                    gov_fov++;
                end else if (gov_scale > cfg_min_scale) begin
                    s = int'(gov_scale) - int'(cfg_step);
                    if (s < int'(cfg_min_scale)) s = cfg_min_scale;
                    gov_scale = s[7:0];
                end
                gov_cooldown = COOLDOWN_LEN;
                res.action   = ACT_REDUCE;
            end else if (load < cfg_headroom * 64'd1000000) begin
                if (gov_streak != 8'hFF) gov_streak++;
                if (gov_streak >= STREAK_NEEDED) begin
                    // scale first, then foveation
                    if (gov_scale < cfg_max_scale) begin
                        s = int'(gov_scale) + int'(cfg_step);
                        if (s > int'(cfg_max_scale)) s = cfg_max_scale;
                        gov_scale = s[7:0];
                    end else if (gov_fov != 0) begin
                        gov_fov--;
                    end
                    gov_streak   = '0;
                    gov_cooldown = COOLDOWN_LEN;
                    res.action   = ACT_INCREASE;
                end
            end else begin
                gov_streak = '0;
            end
        end
        res.scale     = gov_scale;
        res.fov       = gov_fov;
        res.scale_chg = (gov_scale != prev_scale);
        res.fov_chg   = (gov_fov != prev_fov);
        res.avg_us    = gov_avg_q8[AVG_W-1:8];
        return res;
    endfunction

    // APB write. The register lands at the access edge. The port then goes idle
    // before returning, so that psel never drops and rises in the same step.
    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mirror_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(t_reg_idx idx, output logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send one frame beat. Valid is left high after acceptance. The next call or
    // the drain decides whether it drops, so it gets one assignment per step.
    task automatic send_frame(logic [FT_W-1:0] ft);
        int unsigned gap;
        gap = pick_idle();
        if (gap != 0) begin
            i_valid         <= 1'b0;
            i_frame_time_us <= FT_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_frame_time_us <= ft;
        do @(posedge i_clk); while (o_stall);
        frame_outcomes.push_back(govern_frame(ft));
    endtask

    // Every beat yields a result, so the block is idle once the queue is empty.
    task automatic wait_outcomes_drained();
        i_valid <= 1'b0;
        while (frame_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Result side: check accepted beats and make up the stall pattern.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (frame_outcomes.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with nothing expected, expected none, got scale %0d",
                         $time, o_render_scale);
            end else begin
                t_gov_outcome want;
                want = frame_outcomes.pop_front();
                check_field("render_scale", want.scale, o_render_scale);
                check_field("foveation_level", want.fov, o_foveation_level);
                check_field("scale_changed", want.scale_chg, o_scale_changed);
                check_field("foveation_changed", want.fov_chg, o_foveation_changed);
                check_field("action", want.action, o_action);
                check_field("average_time_us", want.avg_us, o_average_time_us);
            end
        end
        if (stall_left == 0) stall_left = pick_idle();
        if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Reset defaults: disabled, so every frame reports full quality and the
    // average stays unloaded.
    task automatic test_disabled_hold();
        send_frame('0);
        send_frame({FT_W{1'b1}});
        send_frame(FT_W'(12345));
        wait_outcomes_drained();
    endtask

    // Each register at all-ones of its width, then at zero, read back both times.
    task automatic test_register_readback();
        logic [31:0] value, got;
        for (int pass = 0; pass < 2; pass++) begin
            for (int i = 0; i < 8; i++) begin
                value = pass ? 32'd0 : (32'd1 << reg_width(t_reg_idx'(i))) - 32'd1;
                apb_write(t_reg_idx'(i), value);
                apb_read(t_reg_idx'(i), got);
                check_field($sformatf("register %0d read-back", i), value, got);
            end
        end
    endtask

    // A zero sample leaves the average unloaded and the next sample loads it.
    // A zero weight freezes the average. A weight over unity acts as unity,
    // which can bring the average back to zero.
    task automatic test_first_sample_and_smoothing();
        apb_write(REG_MIN_SCALE, 32'd30);
        apb_write(REG_MAX_SCALE, 32'd100);
        apb_write(REG_STEP, 32'd5);
        apb_write(REG_SMOOTHING, 32'd0);
        apb_write(REG_OVERSHOOT, 32'd1023);
        apb_write(REG_HEADROOM, 32'd0);
        apb_write(REG_REFRESH, 32'd0);
        apb_write(REG_ENABLE, 32'd1);
        send_frame('0);
        send_frame(FT_W'(40));
        send_frame({FT_W{1'b1}});
        wait_outcomes_drained();
        apb_write(REG_SMOOTHING, 32'd511);
        send_frame({FT_W{1'b1}});   // overshoots: foveation up, cooldown starts
        send_frame('0);             // skipped, average back to zero
        send_frame(FT_W'(7));       // skipped, reloads
        wait_outcomes_drained();
    endtask

    // A zero overshoot ratio makes every frame outside the cooldown a reduction.
    // Foveation climbs to its ceiling. Inverted limits then leave no scale to give
    // up, so the last reductions change nothing but still restart the cooldown.
    task automatic test_reduce_exhaustion();
        apb_write(REG_ENABLE, 32'd0);
        apb_write(REG_MIN_SCALE, 32'd127);
        apb_write(REG_SMOOTHING, 32'd256);
        apb_write(REG_OVERSHOOT, 32'd0);
        apb_write(REG_REFRESH, 32'd1000);
        apb_write(REG_ENABLE, 32'd1);
        repeat (20) send_frame(FT_W'($urandom_range(1, 20'hFFFFF)));
        wait_outcomes_drained();
    endtask

    // Phase 0 uses the reset values but enabled. Phase 1 puts every register at the top of
    // its width, phase 2 near the bottom, and the rest are random. Two phases run
    // disabled and every fourth has no idling. Frames come in runs pitched
    // below headroom, between the ratios or above overshoot, so that streaks
    // complete and quality walks through its full range.
    task automatic test_random_phases();
        logic [31:0]      vals[8];
        longint unsigned  budget_us, level, ft;
        int unsigned      seg_left, r;
        for (int ph = 0; ph < 12; ph++) begin
            no_idle = (ph % 4 == 3);
            case (ph)
                0: begin
                    vals = '{RST_ENABLE, RST_MIN_SCALE, RST_MAX_SCALE, RST_STEP,
                             RST_SMOOTHING, RST_OVERSHOOT, RST_HEADROOM, RST_REFRESH};
                end
                1: vals = '{1, 127, 255, 31, 511, 1023, 1023, 1023};
                2: vals = '{1, 0, 50, 0, 1, 0, 0, 1};
                default: begin
                    vals[REG_MIN_SCALE] = pick_reg_value(REG_MIN_SCALE, 30, 100);
                    vals[REG_MAX_SCALE] = pick_reg_value(REG_MAX_SCALE, 50, 200);
                    vals[REG_STEP]      = pick_reg_value(REG_STEP, 1, 20);
                    vals[REG_SMOOTHING] = pick_reg_value(REG_SMOOTHING, 1, 256);
                    vals[REG_OVERSHOOT] = pick_reg_value(REG_OVERSHOOT, 200, 400);
                    vals[REG_HEADROOM]  = pick_reg_value(REG_HEADROOM, 100, 256);
                    vals[REG_REFRESH]   = pick_reg_value(REG_REFRESH, 45, 240);
                end
            endcase
            for (int i = 1; i < 8; i++) apb_write(t_reg_idx'(i), vals[i]);
            apb_write(REG_ENABLE, (ph == 4 || ph == 8) ? 32'd0 : 32'd1);

            budget_us = 1000000 / ((cfg_refresh_hz == 0) ? 90 : cfg_refresh_hz);
            seg_left  = 0;
            level     = 0;
            repeat (70) begin
                if (seg_left == 0) begin
                    // level is a Q8 fraction of the budget
                    seg_left = $urandom_range(3, 30);
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        level = cfg_headroom * $urandom_range(120, 240) / 256;
                    else if (r < 70)
                        level = $urandom_range(cfg_headroom, cfg_overshoot);
                    else
                        level = cfg_overshoot * $urandom_range(270, 520) / 256 + 1;
                end
                seg_left--;
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    ft = $urandom_range(0, 20'hFFFFF);
                end else if (r < 8) begin
                    ft = 0;
                end else if (r < 10) begin
                    ft = 20'hFFFFF;
                end else begin
                    ft = budget_us * level * $urandom_range(245, 267) / 65536;
                    if (ft > 20'hFFFFF) ft = 20'hFFFFF;
                end
                send_frame(ft[FT_W-1:0]);
            end
            wait_outcomes_drained();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_disabled_hold();
        test_register_readback();
        test_first_sample_and_smoothing();
        test_reduce_exhaustion();
        test_random_phases();
        // let any stray beat show up before the verdict
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && frame_outcomes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hang guard: ends the run with an error if the tests never finish
    initial begin
        #12000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/afqg_pkg.sv
rtl/afqg_mul.sv
rtl/adaptive_frame_quality_governor_unit.sv
sim/adaptive_frame_quality_governor_unit_test.sv
